[rtl/core/mrbp_pkg.sv]
package mrbp_pkg;

    // ASCII characters the parser looks for
    localparam logic [7:0] CH_CR     = 8'd13;
    localparam logic [7:0] CH_LF     = 8'd10;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_ONE    = 8'h31;
    localparam logic [7:0] CH_TWO    = 8'h32;
    localparam logic [7:0] CH_THREE  = 8'h33;
    localparam logic [7:0] CH_FIVE   = 8'h35;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_UP_A   = 8'h41;
    localparam logic [7:0] CH_UP_C   = 8'h43;
    localparam logic [7:0] CH_UP_D   = 8'h44;
    localparam logic [7:0] CH_UP_E   = 8'h45;
    localparam logic [7:0] CH_UP_G   = 8'h47;
    localparam logic [7:0] CH_UP_I   = 8'h49;
    localparam logic [7:0] CH_UP_K   = 8'h4B;
    localparam logic [7:0] CH_UP_M   = 8'h4D;
    localparam logic [7:0] CH_UP_N   = 8'h4E;
    localparam logic [7:0] CH_UP_O   = 8'h4F;
    localparam logic [7:0] CH_UP_R   = 8'h52;
    localparam logic [7:0] CH_UP_S   = 8'h53;
    localparam logic [7:0] CH_UP_T   = 8'h54;
    localparam logic [7:0] CH_UP_U   = 8'h55;
    localparam logic [7:0] CH_LO_F   = 8'h66;
    localparam logic [7:0] CH_LO_N   = 8'h6E;

    // response codes
    localparam logic [2:0] RC_OK      = 3'd0;
    localparam logic [2:0] RC_PROMPT  = 3'd1;
    localparam logic [2:0] RC_ERROR   = 3'd2;
    localparam logic [2:0] RC_UNREAD  = 3'd3;
    localparam logic [2:0] RC_REG     = 3'd4;
    localparam logic [2:0] RC_NEW_MSG = 3'd5;
    localparam logic [2:0] RC_NO_CARR = 3'd6;

    localparam logic [2:0] RS_UNKNOWN = 3'd0;

    // literal chains: one entry per expected character
    localparam int CHAIN_LEN = 31;
    localparam int CHAIN_W   = $clog2(CHAIN_LEN);

    localparam logic [CHAIN_W-1:0] CI_ERROR  = CHAIN_W'(0);
    localparam logic [CHAIN_W-1:0] CI_UNREAD = CHAIN_W'(4);
    localparam logic [CHAIN_W-1:0] CI_CREG   = CHAIN_W'(9);
    localparam logic [CHAIN_W-1:0] CI_CMTI   = CHAIN_W'(13);
    localparam logic [CHAIN_W-1:0] CI_NOCARR = CHAIN_W'(22);

    typedef enum logic [1:0] {
        EX_NEXT   = 2'd0,
        EX_DONE   = 2'd1,
        EX_CREG_X = 2'd2,
        EX_CMTI_D = 2'd3
    } t_chain_exit;

    typedef struct packed {
        logic [7:0]  ch;
        t_chain_exit ex;
        logic [2:0]  code;
    } t_chain_entry;

    localparam t_chain_entry CHAIN [CHAIN_LEN] = '{
        // ERROR
        '{CH_UP_R, EX_NEXT, RC_OK}, '{CH_UP_R, EX_NEXT, RC_OK},
        '{CH_UP_O, EX_NEXT, RC_OK}, '{CH_UP_R, EX_DONE, RC_ERROR},
        // UNREAD
        '{CH_UP_N, EX_NEXT, RC_OK}, '{CH_UP_R, EX_NEXT, RC_OK},
        '{CH_UP_E, EX_NEXT, RC_OK}, '{CH_UP_A, EX_NEXT, RC_OK},
        '{CH_UP_D, EX_DONE, RC_UNREAD},
        // CREG:
        '{CH_UP_E, EX_NEXT, RC_OK}, '{CH_UP_G, EX_NEXT, RC_OK},
        '{CH_COLON, EX_NEXT, RC_OK}, '{CH_SPACE, EX_CREG_X, RC_OK},
        // CMTI: "SM",
        '{CH_UP_T, EX_NEXT, RC_OK}, '{CH_UP_I, EX_NEXT, RC_OK},
        '{CH_COLON, EX_NEXT, RC_OK}, '{CH_SPACE, EX_NEXT, RC_OK},
        '{CH_QUOTE, EX_NEXT, RC_OK}, '{CH_UP_S, EX_NEXT, RC_OK},
        '{CH_UP_M, EX_NEXT, RC_OK}, '{CH_QUOTE, EX_NEXT, RC_OK},
        '{CH_COMMA, EX_CMTI_D, RC_OK},
        // NO CARRIER
        '{CH_UP_O, EX_NEXT, RC_OK}, '{CH_SPACE, EX_NEXT, RC_OK},
        '{CH_UP_C, EX_NEXT, RC_OK}, '{CH_UP_A, EX_NEXT, RC_OK},
        '{CH_UP_R, EX_NEXT, RC_OK}, '{CH_UP_R, EX_NEXT, RC_OK},
        '{CH_UP_I, EX_NEXT, RC_OK}, '{CH_UP_E, EX_NEXT, RC_OK},
        '{CH_UP_R, EX_DONE, RC_NO_CARR}
    };

    typedef enum logic [14:0] {
        ST_IDLE       = 15'b000000000000001,
        ST_O          = 15'b000000000000010,
        ST_GT         = 15'b000000000000100,
        ST_OK_CR      = 15'b000000000001000,
        ST_OK_LF      = 15'b000000000010000,
        ST_ON         = 15'b000000000100000,
        ST_OF         = 15'b000000001000000,
        ST_OFF        = 15'b000000010000000,
        ST_SKIP       = 15'b000000100000000,
        ST_C          = 15'b000001000000000,
        ST_CREG_X     = 15'b000010000000000,
        ST_CREG_COMMA = 15'b000100000000000,
        ST_CREG_STAT  = 15'b001000000000000,
        ST_CMTI_DIGIT = 15'b010000000000000,
        ST_CHAIN      = 15'b100000000000000
    } t_state;

endpackage

[rtl/core/modem_response_byte_parser_top.sv]
// Modem response byte parser.
// Input channel: one received serial byte per transfer on i_rx_byte, with
// i_in_valid / o_in_ready. Output channel: one result per input byte, with
// o_out_valid / i_out_ready; the result flags a recognised reply (OK CR LF,
// prompt, ERROR, UNREAD, CREG status, CMTI new message, NO CARRIER), an
// On<d> / Off<d> switch command, or a registration status update.
// Each accepted byte is held in the input register; its result is loaded
// into the result register when that stage is empty or its item leaves.
// Throughput: one byte per cycle while results are taken; the next-state
// step is a single lookup on the held byte and the parser state, between
// the input register and the result register.
// Reset (synchronous, i_rst_n low): the parser returns to idle and both
// pipeline registers are emptied.
// Receiver stall: the result register holds its item; the input register
// still takes one more byte, after which o_in_ready drops until the result
// is taken. No byte or result is lost or repeated.
// A byte that breaks a match returns the parser to idle and is not examined
// again as a start byte; after any complete reply the parser also goes idle.
module modem_response_byte_parser_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_rx_byte,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic       o_response_valid,
    output logic [2:0] o_response_code,
    output logic       o_switch_valid,
    output logic [3:0] o_switch_index,
    output logic       o_switch_on,
    output logic       o_reg_valid,
    output logic [2:0] o_reg_status
);
    import mrbp_pkg::*;

    // input register
    logic                r_in_valid;
    logic [7:0]          r_byte;

    // parser state
    t_state              r_state, n_state;
    logic [CHAIN_W-1:0]  r_idx, n_idx;

    // result register
    logic                r_out_valid;
    logic                r_resp_v,  n_resp_v;
    logic [2:0]          r_code,    n_code;
    logic                r_sw_v,    n_sw_v;
    logic [3:0]          r_sw_idx,  n_sw_idx;
    logic                r_sw_on,   n_sw_on;
    logic                r_reg_v,   n_reg_v;
    logic [2:0]          r_reg_st,  n_reg_st;

    logic                adv;
    logic                fire;
    logic                is_digit;
    t_chain_entry        entry;

    // the result stage may load when empty or when its item leaves now
    assign adv        = !r_out_valid || i_out_ready;
    assign fire       = r_in_valid && adv;
    assign o_in_ready = !r_in_valid || adv;

    assign is_digit = (r_byte >= CH_ZERO) && (r_byte <= CH_NINE);
    assign entry    = CHAIN[r_idx];

    always_comb begin
        n_state  = ST_IDLE;
        n_idx    = r_idx;
        n_resp_v = 1'b0;
        n_code   = RC_OK;
        n_sw_v   = 1'b0;
        n_sw_idx = 4'd0;
        n_sw_on  = 1'b0;
        n_reg_v  = 1'b0;
        n_reg_st = RS_UNKNOWN;
        case (r_state)
            ST_IDLE: begin
                if (r_byte == CH_UP_O) begin
                    n_state = ST_O;
                end else if (r_byte == CH_GT) begin
                    n_state = ST_GT;
                end else if (r_byte == CH_UP_E) begin
                    n_state = ST_CHAIN;
                    n_idx   = CI_ERROR;
                end else if (r_byte == CH_UP_U) begin
                    n_state = ST_CHAIN;
                    n_idx   = CI_UNREAD;
                end else if (r_byte == CH_UP_C) begin
                    n_state = ST_C;
                end else if (r_byte == CH_UP_N) begin
                    n_state = ST_CHAIN;
                    n_idx   = CI_NOCARR;
                end else if (r_byte == CH_UP_M) begin
                    n_state = ST_SKIP;
                end
            end
            ST_O: begin
                if (r_byte == CH_UP_K) begin
                    n_state = ST_OK_CR;
                end else if (r_byte == CH_LO_N) begin
                    n_state = ST_ON;
                end else if (r_byte == CH_LO_F) begin
                    n_state = ST_OF;
                end
            end
            ST_GT: begin
                if (r_byte == CH_SPACE) begin
                    n_resp_v = 1'b1;
                    n_code   = RC_PROMPT;
                end
            end
            ST_OK_CR: begin
                if (r_byte == CH_CR) begin
                    n_state = ST_OK_LF;
                end
            end
            ST_OK_LF: begin
                if (r_byte == CH_LF) begin
                    n_resp_v = 1'b1;
                    n_code   = RC_OK;
                end
            end
            ST_ON, ST_OFF: begin
                if (is_digit) begin
                    n_sw_v   = 1'b1;
                    n_sw_on  = (r_state == ST_ON);
                    n_sw_idx = r_byte[3:0];
                end
            end
            ST_OF: begin
                if (r_byte == CH_LO_F) begin
                    n_state = ST_OFF;
                end
            end
            ST_C: begin
                if (r_byte == CH_UP_R) begin
                    n_state = ST_CHAIN;
                    n_idx   = CI_CREG;
                end else if (r_byte == CH_UP_M) begin
                    n_state = ST_CHAIN;
                    n_idx   = CI_CMTI;
                end
            end
            ST_CREG_X: begin
                // mode digit: report unknown status, no reply yet
                if (r_byte == CH_ZERO || r_byte == CH_ONE) begin
                    n_state  = ST_CREG_COMMA;
                    n_reg_v  = 1'b1;
                    n_reg_st = RS_UNKNOWN;
                end
            end
            ST_CREG_COMMA: begin
                if (r_byte == CH_COMMA) begin
                    n_state = ST_CREG_STAT;
                end
            end
            ST_CREG_STAT: begin
                if (r_byte == CH_ONE || r_byte == CH_FIVE) begin
                    n_resp_v = 1'b1;
                    n_code   = RC_REG;
                    n_reg_v  = 1'b1;
                    n_reg_st = r_byte[2:0];
                end else if (r_byte == CH_TWO || r_byte == CH_THREE) begin
                    // searching or denied reports as an error reply
                    n_resp_v = 1'b1;
                    n_code   = RC_ERROR;
                    n_reg_v  = 1'b1;
                    n_reg_st = r_byte[2:0];
                end
            end
            ST_CMTI_DIGIT: begin
                if (is_digit) begin
                    n_resp_v = 1'b1;
                    n_code   = RC_NEW_MSG;
                end
            end
            ST_CHAIN: begin
                if (r_byte == entry.ch) begin
                    case (entry.ex)
                        EX_NEXT: begin
                            n_state = ST_CHAIN;
                            n_idx   = r_idx + CHAIN_W'(1);
                        end
                        EX_DONE: begin
                            n_resp_v = 1'b1;
                            n_code   = entry.code;
                        end
                        EX_CREG_X: begin
                            n_state = ST_CREG_X;
                        end
                        EX_CMTI_D: begin
                            n_state = ST_CMTI_DIGIT;
                        end
                        default: begin
                            n_state = ST_IDLE;
                        end
                    endcase
                end
            end
            // swallow state: drop this byte and go idle
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= ST_IDLE;
            r_idx       <= CI_ERROR;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (fire) begin
                r_out_valid <= 1'b1;
                r_state     <= n_state;
                r_idx       <= n_idx;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload: hold the byte until parsed, hold the result until taken
    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_byte <= i_rx_byte;
        end
        if (fire) begin
            r_resp_v <= n_resp_v;
            r_code   <= n_code;
            r_sw_v   <= n_sw_v;
            r_sw_idx <= n_sw_idx;
            r_sw_on  <= n_sw_on;
            r_reg_v  <= n_reg_v;
            r_reg_st <= n_reg_st;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_response_valid = r_resp_v;
    assign o_response_code  = r_code;
    assign o_switch_valid   = r_sw_v;
    assign o_switch_index   = r_sw_idx;
    assign o_switch_on      = r_sw_on;
    assign o_reg_valid      = r_reg_v;
    assign o_reg_status     = r_reg_st;

endmodule
